### src/message_packetizer_assert.svh
// Assertion macros shared by the message packetizer modules.
`ifndef MESSAGE_PACKETIZER_ASSERT_SVH
`define MESSAGE_PACKETIZER_ASSERT_SVH

`ifndef SYNTHESIS
`define MPK_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define MPK_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define MPK_ASSERT(lbl, clk, rstn, prop, msg)
`define MPK_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

### src/mpk_pkg.sv
// Types, constants and register codes of the message packetizer.
package mpk_pkg;

	localparam int DEF_MAX_CHUNK = 31;
	localparam int DEF_MAX_NAME = 15;

	localparam int CLEN_W = 5;
	localparam int NLEN_W = 4;
	localparam int NAME_CHARS = 15;
	localparam int NAME_BITS = 8 * NAME_CHARS;
	localparam int DESC_DEPTH = 2;

	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 64;

	localparam logic [2:0] HDR_FLAG = 3'b101;
	localparam logic [3:0] CRC_PLACEHOLDER = 4'hF;

	localparam logic [1:0] REG_NAME_LENGTH = 2'd0;
	localparam logic [1:0] REG_NAME_LOW = 2'd1;
	localparam logic [1:0] REG_NAME_HIGH = 2'd2;

	typedef struct packed {
		logic [CLEN_W-1:0] clen;
		logic last;
	} desc_t;

	typedef struct packed {
		logic [NLEN_W-1:0] length;
		logic [NAME_BITS-1:0] chars;
	} name_cfg_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_HDR1,
		BK_NAME,
		BK_DATA
	} back_state_t;

endpackage

### src/mpk_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mpk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/mpk_front.sv
// Front end: takes text bytes, fills the chunk bank and closes chunks.
`include "message_packetizer_assert.svh"

module mpk_front #(
	parameter int MAX_CHUNK = 31
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata,
	input logic s_tlast,
	output logic ram_we,
	output logic [$clog2(MAX_CHUNK+1):0] ram_waddr,
	output logic [7:0] ram_wdata,
	output logic push,
	output mpk_pkg::desc_t push_data,
	input logic fifo_full
);
	import mpk_pkg::*;

	localparam int CW = $clog2(MAX_CHUNK + 1);

	logic [CW-1:0] fill_q;
	logic [CW-1:0] fill_next;
	logic wbank_q;
	logic accept;
	logic close;

	assign s_tready = !fifo_full;
	assign accept = s_tvalid && s_tready;
	assign fill_next = fill_q + CW'(1);
	assign close = (fill_next == CW'(MAX_CHUNK)) || s_tlast;

	assign ram_we = accept;
	assign ram_waddr = {wbank_q, fill_q};
	assign ram_wdata = s_tdata;

	assign push = accept && close;
	assign push_data.clen = CLEN_W'(fill_next);
	assign push_data.last = s_tlast;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			wbank_q <= 1'b0;
		end else if (accept) begin
			if (close) begin
				fill_q <= '0;
				wbank_q <= !wbank_q;
			end else begin
				fill_q <= fill_next;
			end
		end
	end

	`MPK_ASSERT(a_fill_range, clk, arst_n, fill_q < CW'(MAX_CHUNK), "chunk fill out of range")
	`MPK_ASSERT_NEVER(a_push_full, clk, arst_n, push && fifo_full, "chunk closed into full queue")

endmodule

### src/mpk_desc_fifo.sv
// Two-entry queue of closed chunk descriptors between front and back.
`include "message_packetizer_assert.svh"

module mpk_desc_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input mpk_pkg::desc_t push_data,
	output logic full,
	input logic pop,
	output logic head_valid,
	output mpk_pkg::desc_t head
);
	import mpk_pkg::*;

	localparam int PW = $clog2(DESC_DEPTH);

	desc_t entry_q [DESC_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0] count_q;

	assign full = (count_q == (PW+1)'(DESC_DEPTH));
	assign head_valid = (count_q != '0);
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

	`MPK_ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && !head_valid, "pop from empty queue")
	`MPK_ASSERT(a_count_range, clk, arst_n, count_q <= (PW+1)'(DESC_DEPTH), "queue count out of range")

endmodule

### src/mpk_back.sv
// Back end: sequences header, name and chunk bytes of each package onto the output.
`include "message_packetizer_assert.svh"

module mpk_back #(
	parameter int MAX_CHUNK = 31,
	parameter int MAX_NAME = 15
) (
	input logic clk,
	input logic arst_n,
	input mpk_pkg::name_cfg_t cfg,
	input logic desc_valid,
	input mpk_pkg::desc_t desc,
	output logic desc_pop,
	output logic ram_re,
	output logic [$clog2(MAX_CHUNK+1):0] ram_raddr,
	input logic [7:0] ram_rdata,
	output logic m_tvalid,
	input logic m_tready,
	output logic [7:0] m_tdata,
	output logic m_tlast,
	output logic m_tuser
);
	import mpk_pkg::*;

	localparam int CW = $clog2(MAX_CHUNK + 1);
	localparam int CNTW = (CW > NLEN_W) ? CW : NLEN_W;

	back_state_t state_q, state_d;
	logic [CNTW-1:0] cnt_q, cnt_d;
	logic rbank_q, rbank_d;

	logic [NLEN_W-1:0] nlen;
	logic [CLEN_W-1:0] clen;
	logic adv_out;
	logic adv_s1;

	logic gen_valid;
	logic gen_data;
	logic [7:0] gen_byte;
	logic gen_eop;
	logic gen_eom;

	logic v_s1;
	logic data_s1;
	logic [7:0] byte_s1;
	logic eop_s1;
	logic eom_s1;

	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic out_eop_q;
	logic out_eom_q;

	assign nlen = (cfg.length > NLEN_W'(MAX_NAME)) ? NLEN_W'(MAX_NAME) : cfg.length;
	assign clen = desc.clen;
	assign adv_out = !out_valid_q || m_tready;
	assign adv_s1 = !v_s1 || adv_out;

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		rbank_d = rbank_q;
		gen_valid = 1'b0;
		gen_data = 1'b0;
		gen_byte = '0;
		gen_eop = 1'b0;
		gen_eom = 1'b0;
		desc_pop = 1'b0;
		case (state_q)
			BK_IDLE: begin
				gen_byte = {HDR_FLAG, nlen, clen[4]};
				if (desc_valid) begin
					gen_valid = 1'b1;
					if (adv_s1) begin
						state_d = BK_HDR1;
					end
				end
			end
			BK_HDR1: begin
				gen_valid = 1'b1;
				gen_byte = {clen[3:0], CRC_PLACEHOLDER};
				if (adv_s1) begin
					cnt_d = '0;
					state_d = (nlen != '0) ? BK_NAME : BK_DATA;
				end
			end
			BK_NAME: begin
				gen_valid = 1'b1;
				gen_byte = cfg.chars[8*cnt_q[NLEN_W-1:0] +: 8];
				if (adv_s1) begin
					if (cnt_q[NLEN_W-1:0] == nlen - NLEN_W'(1)) begin
						cnt_d = '0;
						state_d = BK_DATA;
					end else begin
						cnt_d = cnt_q + CNTW'(1);
					end
				end
			end
			BK_DATA: begin
				gen_valid = 1'b1;
				gen_data = 1'b1;
				gen_eop = (cnt_q[CW-1:0] == clen[CW-1:0] - CW'(1));
				gen_eom = gen_eop && desc.last;
				if (adv_s1) begin
					if (gen_eop) begin
						desc_pop = 1'b1;
						rbank_d = !rbank_q;
						cnt_d = '0;
						state_d = BK_IDLE;
					end else begin
						cnt_d = cnt_q + CNTW'(1);
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	assign ram_re = gen_valid && gen_data && adv_s1;
	assign ram_raddr = {rbank_q, cnt_q[CW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			cnt_q <= '0;
			rbank_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			rbank_q <= rbank_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= gen_valid;
			end
			if (adv_out) begin
				out_valid_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			data_s1 <= gen_data;
			byte_s1 <= gen_byte;
			eop_s1 <= gen_eop;
			eom_s1 <= gen_eom;
		end
		if (adv_out) begin
			out_byte_q <= data_s1 ? ram_rdata : byte_s1;
			out_eop_q <= eop_s1;
			out_eom_q <= eom_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_byte_q;
	assign m_tlast = out_eop_q;
	assign m_tuser = out_eom_q;

	`MPK_ASSERT(a_busy_has_desc, clk, arst_n, (state_q != BK_IDLE) |-> desc_valid, "package in progress without descriptor")
	`MPK_ASSERT(a_eom_on_eop, clk, arst_n, (m_tvalid && m_tuser) |-> m_tlast, "message end off package end")

endmodule

### src/message_packetizer.sv
// Top level of the message packetizer: configuration registers and block wiring.
//
// Text bytes enter on the s_ stream, one transfer per cycle while a chunk fills,
// and are written into a two-bank chunk RAM; a chunk closes when it holds
// MAX_CHUNK bytes or on the byte marked by s_tlast, and its descriptor goes into
// a two-entry queue, so the input stalls only while two closed chunks wait. The
// back end sends each package on the m_ stream at one byte per cycle while
// m_tready is high, through the RAM's single read port: two header bytes, the
// name bytes, then the chunk bytes, with the next package's first header byte
// following directly when its descriptor is already queued.
// m_tlast marks the last byte of a package and m_tuser the last byte of the
// message. Configuration sits on an APB-style port at byte addresses 0, 8 and 16
// and must only be written while the block is idle. No clearing pass follows reset.
`include "message_packetizer_assert.svh"

module message_packetizer #(
	parameter int MAX_CHUNK = mpk_pkg::DEF_MAX_CHUNK,
	parameter int MAX_NAME = mpk_pkg::DEF_MAX_NAME
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [mpk_pkg::CFG_ADDR_W-1:0] paddr,
	input logic [mpk_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [mpk_pkg::CFG_DATA_W-1:0] prdata,
	output logic pready,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata, // text_byte
	input logic s_tlast,
	output logic m_tvalid,
	input logic m_tready,
	output logic [7:0] m_tdata, // out_byte
	output logic m_tlast,
	output logic m_tuser // end_of_message
);
	import mpk_pkg::*;

	localparam int CW = $clog2(MAX_CHUNK + 1);
	localparam int AW = CW + 1;

	logic [NLEN_W-1:0] name_length_q;
	logic [63:0] name_low_q;
	logic [55:0] name_high_q;
	logic [1:0] reg_index;
	logic cfg_write;
	name_cfg_t name_cfg;

	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0] ram_wdata;
	logic ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0] ram_rdata;

	logic push;
	desc_t push_data;
	logic fifo_full;
	logic desc_pop;
	logic desc_valid;
	desc_t desc_head;

	assign pready = 1'b1;
	assign reg_index = paddr[4:3];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_length_q <= NLEN_W'(1);
			name_low_q <= '0;
			name_high_q <= '0;
		end else if (cfg_write) begin
			case (reg_index)
				REG_NAME_LENGTH: name_length_q <= pwdata[NLEN_W-1:0];
				REG_NAME_LOW: name_low_q <= pwdata;
				REG_NAME_HIGH: name_high_q <= pwdata[55:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_index)
			REG_NAME_LENGTH: prdata = CFG_DATA_W'(name_length_q);
			REG_NAME_LOW: prdata = name_low_q;
			REG_NAME_HIGH: prdata = CFG_DATA_W'(name_high_q);
			default: prdata = '0;
		endcase
	end

	assign name_cfg.length = name_length_q;
	assign name_cfg.chars = {name_high_q, name_low_q};

	mpk_front #(
		.MAX_CHUNK(MAX_CHUNK)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.push(push),
		.push_data(push_data),
		.fifo_full(fifo_full)
	);

	mpk_ram #(
		.WIDTH(8),
		.DEPTH(2 ** AW)
	) u_chunk_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	mpk_desc_fifo u_desc_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(fifo_full),
		.pop(desc_pop),
		.head_valid(desc_valid),
		.head(desc_head)
	);

	mpk_back #(
		.MAX_CHUNK(MAX_CHUNK),
		.MAX_NAME(MAX_NAME)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(name_cfg),
		.desc_valid(desc_valid),
		.desc(desc_head),
		.desc_pop(desc_pop),
		.ram_re(ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	`MPK_ASSERT_NEVER(a_same_bank_access, clk, arst_n, ram_we && ram_re && (ram_waddr == ram_raddr), "chunk bank written while read")

endmodule
